/* rtl/slib_pkg.sv */
// Shared constants, codes and types of the serial line input buffer.
// No dependencies; imported by every module of the block except the RAM.
package slib_pkg;

  // Line store geometry.
  localparam int BufDepth = 64;
  localparam int AddrW    = (BufDepth > 1) ? $clog2(BufDepth) : 1;
  localparam int CntW     = $clog2(BufDepth + 1);

  // Largest line read, terminator included.
  localparam int LineMax  = 64;
  localparam int TakeW    = $clog2(LineMax);

  localparam int DropW    = 16;
  localparam logic [DropW-1:0] DropMax = '1;

  // Operation codes of an input item.
  localparam logic [1:0] OpRx   = 2'd0;
  localparam logic [1:0] OpChar = 2'd1;
  localparam logic [1:0] OpLine = 2'd2;

  // Result kinds.
  localparam logic [2:0] KindEcho  = 3'd0;
  localparam logic [2:0] KindChar  = 3'd1;
  localparam logic [2:0] KindLine  = 3'd2;
  localparam logic [2:0] KindNone  = 3'd3;
  localparam logic [2:0] KindEmpty = 3'd4;

  // Special characters.
  localparam logic [7:0] ChCr  = 8'd13;
  localparam logic [7:0] ChLf  = 8'd10;
  localparam logic [7:0] ChBs  = 8'd8;
  localparam logic [7:0] ChDel = 8'd127;

  // Register indexes (word address bit 2).
  localparam logic RegEcho = 1'b0;
  localparam logic RegText = 1'b1;

  typedef struct packed {
    logic echo;
    logic text;
  } cfg_t;

endpackage

/* rtl/serial_line_input_buffer.sv */
// Top level of the serial line input buffer: configuration registers,
// sequencer, wrap adder and line store RAM. Depends on slib_pkg.
//
// Usage: an item (op_i, rx_byte_i, line_size_i) is taken at a rising edge
// where start is high and busy is low. Received bytes (op 0) are stored in a
// circular line store, optionally echoed; op 1 pops the oldest byte and op 2
// hands out a whole line. Results appear on the result ports for exactly one
// cycle each, marked by out_strobe_o, with last_o high on the final one of
// an item; the receiver cannot stall them. fill_count_o, overrun_count_o and
// line_ready_o show the buffer state after the item.
// Busy: busy is high in the decode state after the accepting edge, in an
// extra state for the line feed echo of a carriage return, and in the line
// read state while the bytes of a line read (up to 63) are fetched: the line
// store RAM has one read port and its read is registered, so a line read
// streams one byte a cycle. No new item is taken until busy falls again.
// Reset empties the buffer, clears the end-of-line flag, the overrun count
// and both configuration registers; no clearing pass is needed because only
// stored bytes are ever read. Configuration is written over the APB port
// (echo enable at address 0, text mode at address 4) by the user, only while
// the block is idle; the block itself does not enforce this.
module serial_line_input_buffer import slib_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  // APB configuration port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // Command channel
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       op_i,
  input  logic [7:0]       rx_byte_i,
  input  logic [6:0]       line_size_i,
  // Result channel
  output logic             out_strobe_o,
  output logic [2:0]       kind_o,
  output logic [7:0]       data_o,
  output logic             last_o,
  output logic [6:0]       fill_count_o,
  output logic [DropW-1:0] overrun_count_o,
  output logic             line_ready_o
);

  cfg_t             cfg;
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [7:0]       ram_wdata;
  logic             ram_re;
  logic [AddrW-1:0] ram_raddr;
  logic [7:0]       ram_rdata;
  logic [AddrW-1:0] wrap_base;
  logic [CntW-1:0]  wrap_offset;
  logic [AddrW-1:0] wrap_sum;

  slib_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The one adder shared by every pointer update and store address.
  slib_wrap u_wrap (
    .base_i   (wrap_base),
    .offset_i (wrap_offset),
    .sum_o    (wrap_sum)
  );

  slib_ram #(
    .Width (8),
    .Depth (BufDepth),
    .AddrW (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  slib_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .start_i         (start),
    .busy_o          (busy),
    .op_i            (op_i),
    .rx_byte_i       (rx_byte_i),
    .line_size_i     (line_size_i),
    .ram_we_o        (ram_we),
    .ram_waddr_o     (ram_waddr),
    .ram_wdata_o     (ram_wdata),
    .ram_re_o        (ram_re),
    .ram_raddr_o     (ram_raddr),
    .ram_rdata_i     (ram_rdata),
    .wrap_base_o     (wrap_base),
    .wrap_offset_o   (wrap_offset),
    .wrap_sum_i      (wrap_sum),
    .strobe_o        (out_strobe_o),
    .kind_o          (kind_o),
    .data_o          (data_o),
    .last_o          (last_o),
    .fill_count_o    (fill_count_o),
    .overrun_count_o (overrun_count_o),
    .line_ready_o    (line_ready_o)
  );

endmodule

/* rtl/slib_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module slib_ram #(
  parameter int Width = 8,
  parameter int Depth = 64,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/slib_wrap.sv */
// Circular address adder: base plus offset, wrapped at the line store depth.
// Depends on slib_pkg.
module slib_wrap import slib_pkg::*; (
  input  logic [AddrW-1:0] base_i,
  input  logic [CntW-1:0]  offset_i,
  output logic [AddrW-1:0] sum_o
);

  localparam int SumW = CntW + 1;

  logic [SumW-1:0] sum;
  logic [SumW-1:0] wrapped;

  // The offset never exceeds the depth, so one subtract is enough.
  assign sum     = SumW'(base_i) + SumW'(offset_i);
  assign wrapped = (sum >= SumW'(BufDepth)) ? (sum - SumW'(BufDepth)) : sum;
  assign sum_o   = AddrW'(wrapped);

endmodule

/* rtl/slib_regs.sv */
// APB-style configuration registers: echo enable and text mode.
// Depends on slib_pkg.
module slib_regs import slib_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t cfg_d, cfg_q;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr[2])
        RegEcho: cfg_d.echo = pwdata[0];
        RegText: cfg_d.text = pwdata[0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegEcho: prdata = {31'd0, cfg_q.echo};
      RegText: prdata = {31'd0, cfg_q.text};
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/slib_ctrl.sv */
// Sequencer of the line buffer: holds the circular store pointers and flags,
// drives the line store RAM and the shared wrap adder. Depends on slib_pkg.
module slib_ctrl import slib_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             start_i,
  output logic             busy_o,
  input  logic [1:0]       op_i,
  input  logic [7:0]       rx_byte_i,
  input  logic [6:0]       line_size_i,
  // RAM side
  output logic             ram_we_o,
  output logic [AddrW-1:0] ram_waddr_o,
  output logic [7:0]       ram_wdata_o,
  output logic             ram_re_o,
  output logic [AddrW-1:0] ram_raddr_o,
  input  logic [7:0]       ram_rdata_i,
  // Wrap adder side
  output logic [AddrW-1:0] wrap_base_o,
  output logic [CntW-1:0]  wrap_offset_o,
  input  logic [AddrW-1:0] wrap_sum_i,
  // Results
  output logic             strobe_o,
  output logic [2:0]       kind_o,
  output logic [7:0]       data_o,
  output logic             last_o,
  output logic [6:0]       fill_count_o,
  output logic [DropW-1:0] overrun_count_o,
  output logic             line_ready_o
);

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_DECODE  = 4'b0010,
    S_ECHO_LF = 4'b0100,
    S_LREAD   = 4'b1000
  } state_e;

  state_e state_d, state_q;

  logic [AddrW-1:0] head_d, head_q;
  logic [CntW-1:0]  count_d, count_q;
  logic             eol_d, eol_q;
  logic [DropW-1:0] drop_d, drop_q;

  logic [AddrW-1:0] rd_ptr_d, rd_ptr_q;
  logic [TakeW-1:0] rem_d, rem_q;
  logic [1:0]       op_d, op_q;
  logic [7:0]       byte_d, byte_q;
  logic [6:0]       size_d, size_q;

  logic             emit_d, emit_q;
  logic [2:0]       kind_d, kind_q;
  logic [7:0]       data_d, data_q;
  logic             last_d, last_q;
  logic             from_ram_d, from_ram_q;

  logic             accept;
  logic [TakeW-1:0] size_m1;
  logic             line_ok;
  logic [TakeW-1:0] take;
  logic [7:0]       rx_stored;

  assign busy_o = (state_q != S_IDLE);
  assign accept = start_i & ~busy_o;

  // Clamped line capacity minus the terminator.
  always_comb begin
    if (size_q == 7'd0) begin
      size_m1 = '0;
    end else if (size_q > 7'(LineMax)) begin
      size_m1 = TakeW'(LineMax - 1);
    end else begin
      size_m1 = TakeW'(size_q - 7'd1);
    end
  end

  assign line_ok   = eol_q || (int'(count_q) >= int'(size_m1));
  assign take      = (int'(count_q) >= int'(size_m1)) ? size_m1 : TakeW'(count_q);
  assign rx_stored = (cfg_i.text && (byte_q == ChCr)) ? ChLf : byte_q;

  // Operand selection for the shared wrap adder.
  always_comb begin
    wrap_base_o   = head_q;
    wrap_offset_o = count_q;
    case (state_q)
      S_DECODE: begin
        case (op_q)
          OpChar:  wrap_offset_o = CntW'(1);
          OpLine:  wrap_offset_o = CntW'(take);
          default: wrap_offset_o = count_q;
        endcase
      end
      S_LREAD: begin
        wrap_base_o   = rd_ptr_q;
        wrap_offset_o = CntW'(1);
      end
      default: wrap_offset_o = count_q;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    count_d    = count_q;
    eol_d      = eol_q;
    drop_d     = drop_q;
    rd_ptr_d   = rd_ptr_q;
    rem_d      = rem_q;
    op_d       = op_q;
    byte_d     = byte_q;
    size_d     = size_q;
    emit_d     = 1'b0;
    kind_d     = kind_q;
    data_d     = data_q;
    last_d     = last_q;
    from_ram_d = 1'b0;
    ram_we_o   = 1'b0;
    ram_waddr_o = wrap_sum_i;
    ram_wdata_o = rx_stored;
    ram_re_o    = 1'b0;
    ram_raddr_o = head_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d    = op_i;
          byte_d  = rx_byte_i;
          size_d  = line_size_i;
          state_d = S_DECODE;
        end
      end

      S_DECODE: begin
        state_d = S_IDLE;
        case (op_q)
          OpRx: begin
            if (count_q >= CntW'(BufDepth)) begin
              if (drop_q != DropMax) begin
                drop_d = drop_q + DropW'(1);
              end
            end else if (cfg_i.text) begin
              if ((byte_q == ChLf) || (byte_q == ChCr)) begin
                eol_d = 1'b1;
              end
              if ((rx_stored == ChDel) || (rx_stored == ChBs)) begin
                if (count_q != '0) begin
                  count_d = count_q - CntW'(1);
                end
              end else begin
                ram_we_o = 1'b1;
                count_d  = count_q + CntW'(1);
              end
            end else begin
              ram_we_o = 1'b1;
              count_d  = count_q + CntW'(1);
            end
            if (cfg_i.echo) begin
              emit_d = 1'b1;
              kind_d = KindEcho;
              data_d = byte_q;
              last_d = (byte_q != ChCr);
              if (byte_q == ChCr) begin
                state_d = S_ECHO_LF;
              end
            end
          end

          OpChar: begin
            emit_d = 1'b1;
            last_d = 1'b1;
            if (count_q == '0) begin
              kind_d = KindNone;
              data_d = '0;
            end else begin
              ram_re_o   = 1'b1;
              head_d     = wrap_sum_i;
              count_d    = count_q - CntW'(1);
              kind_d     = KindChar;
              from_ram_d = 1'b1;
            end
          end

          OpLine: begin
            if (!line_ok) begin
              emit_d = 1'b1;
              kind_d = KindNone;
              data_d = '0;
              last_d = 1'b1;
            end else begin
              head_d  = wrap_sum_i;
              count_d = count_q - CntW'(take);
              drop_d  = '0;
              eol_d   = 1'b0;
              if (take == '0) begin
                emit_d = 1'b1;
                kind_d = KindEmpty;
                data_d = '0;
                last_d = 1'b1;
              end else begin
                rd_ptr_d = head_q;
                rem_d    = take;
                state_d  = S_LREAD;
              end
            end
          end

          default: state_d = S_IDLE;
        endcase
      end

      S_ECHO_LF: begin
        emit_d  = 1'b1;
        kind_d  = KindEcho;
        data_d  = ChLf;
        last_d  = 1'b1;
        state_d = S_IDLE;
      end

      S_LREAD: begin
        // One stored byte is fetched per cycle; it leaves on the next.
        ram_re_o    = 1'b1;
        ram_raddr_o = rd_ptr_q;
        rd_ptr_d    = wrap_sum_i;
        rem_d       = rem_q - TakeW'(1);
        emit_d      = 1'b1;
        kind_d      = KindLine;
        from_ram_d  = 1'b1;
        last_d      = (rem_q == TakeW'(1));
        if (rem_q == TakeW'(1)) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      head_q     <= '0;
      count_q    <= '0;
      eol_q      <= 1'b0;
      drop_q     <= '0;
      emit_q     <= 1'b0;
      from_ram_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      count_q    <= count_d;
      eol_q      <= eol_d;
      drop_q     <= drop_d;
      emit_q     <= emit_d;
      from_ram_q <= from_ram_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_ptr_q <= rd_ptr_d;
    rem_q    <= rem_d;
    op_q     <= op_d;
    byte_q   <= byte_d;
    size_q   <= size_d;
    kind_q   <= kind_d;
    data_q   <= data_d;
    last_q   <= last_d;
  end

  assign strobe_o        = emit_q;
  assign kind_o          = kind_q;
  assign data_o          = from_ram_q ? ram_rdata_i : data_q;
  assign last_o          = last_q;
  assign fill_count_o    = 7'(count_q);
  assign overrun_count_o = drop_q;
  assign line_ready_o    = eol_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(BufDepth))
    else $error("fill count exceeds the store depth");

  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_DECODE))
    else $error("accepted item did not enter decode");

  a_lread_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LREAD) |-> (rem_q != '0))
    else $error("line read running with no bytes left");

  a_ram_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re_o |=> (emit_q && from_ram_q))
    else $error("fetched byte was not delivered");
`endif

endmodule
